@@ design/ilc_pkg.sv @@
// Package for the indexed word list: field widths, opcodes, status codes
// and the command/status structs shared by controller and datapath.
// No dependencies.
`default_nettype none

package ilc_pkg;

    localparam int DEF_CAPACITY  = 256;
    localparam int DEF_WORD_BITS = 32;

    localparam int OPCODE_W    = 2;
    localparam int POS_W       = 8;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 9;

    // s_tdata: opcode, position, item_value from bit 0 up, padded to bytes
    localparam int S_OPCODE_LSB = 0;
    localparam int S_POS_LSB    = S_OPCODE_LSB + OPCODE_W;
    localparam int S_VALUE_LSB  = S_POS_LSB + POS_W;
    localparam int S_FIELDS_W   = S_VALUE_LSB + VALUE_W;
    localparam int S_TDATA_W    = ((S_FIELDS_W + 7) / 8) * 8;

    // m_tdata: read_value, status, entry_count from bit 0 up, padded to bytes
    localparam int M_VALUE_LSB  = 0;
    localparam int M_STATUS_LSB = M_VALUE_LSB + VALUE_W;
    localparam int M_COUNT_LSB  = M_STATUS_LSB + STATUS_W;
    localparam int M_FIELDS_W   = M_COUNT_LSB + COUNT_OUT_W;
    localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_WRITE  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                capture;     // latch the input request
        logic                append;      // write at end, bump count
        logic                wr_pos;      // overwrite entry at position
        logic                rd_pos;      // read entry at position
        logic                shift_start; // load shift index with position
        logic                shift_step;  // move one entry down
        logic                dec_count;   // drop the last entry
        logic                load_out;    // load output register
        logic [STATUS_W-1:0] res_status;
        logic                res_read;    // result carries the read word
    } cmd_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                in_range;
        logic                full;
        logic                shift_done;
    } stat_t;

endpackage

`default_nettype wire

@@ design/indexed_list_with_compaction.sv @@
// Top level of the indexed word list with compaction.
// Instantiates ilc_controller and ilc_datapath; uses ilc_pkg.
//
//   channel | dir | ports                       | payload (low bit first)
//   s_      | in  | s_tvalid s_tready s_tdata   | opcode, position, item_value
//   m_      | out | m_tvalid m_tready m_tdata   | read_value, status, entry_count
//
// Each request is captured, executed and then published; a read adds a wait
// for the memory word, and a delete of any entry but the last first moves the
// later entries down: one entry moves down per cycle.
// Reset clears the fill count; entry contents stay undefined until written.
// A new request is taken while a result waits; a finished result holds
// until the output register frees up.
`default_nettype none

module indexed_list_with_compaction #(
    parameter int CAPACITY  = ilc_pkg::DEF_CAPACITY,
    parameter int WORD_BITS = ilc_pkg::DEF_WORD_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // opcode[1:0], position[9:2], item_value[41:10], zero pad above
    input  wire logic [ilc_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // read_value[31:0], status[33:32], entry_count[42:34], zero pad above
    output logic      [ilc_pkg::M_TDATA_W-1:0] m_tdata
);

    ilc_pkg::cmd_t  cmd;
    ilc_pkg::stat_t stat;

    ilc_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ilc_datapath #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_tdata)
    );

endmodule

`default_nettype wire

@@ design/ilc_datapath.sv @@
// Datapath of the indexed word list: request registers, entry memory,
// fill count, shift index and output payload register. Uses ilc_pkg.
`default_nettype none

module ilc_datapath #(
    parameter int CAPACITY  = ilc_pkg::DEF_CAPACITY,
    parameter int WORD_BITS = ilc_pkg::DEF_WORD_BITS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [ilc_pkg::S_TDATA_W-1:0]  in_data,
    input  wire ilc_pkg::cmd_t                  cmd,
    output ilc_pkg::stat_t                      stat,
    output logic      [ilc_pkg::M_TDATA_W-1:0]  out_data
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = ((CNT_W > ilc_pkg::POS_W) ? CNT_W : ilc_pkg::POS_W) + 1;

    logic [ilc_pkg::OPCODE_W-1:0] op_reg;
    logic [ilc_pkg::POS_W-1:0]    pos_reg;
    logic [WORD_BITS-1:0]         val_reg;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             idx_reg, idx_next;
    logic                         pend_reg, pend_next;
    logic [ADDR_W-1:0]            wa_reg, wa_next;

    logic [WORD_BITS-1:0] mem [CAPACITY];
    logic [WORD_BITS-1:0] rd_data_reg;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_wa;
    logic [WORD_BITS-1:0] mem_wd;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_ra;
    logic                 has_next;

    logic [ilc_pkg::VALUE_W-1:0]     out_value_reg;
    logic [ilc_pkg::STATUS_W-1:0]    out_status_reg;
    logic [ilc_pkg::COUNT_OUT_W-1:0] out_count_reg;

    assign has_next = ((CNT_W+1)'(idx_reg) + (CNT_W+1)'(1)) < (CNT_W+1)'(count_reg);

    assign stat.op         = op_reg;
    assign stat.in_range   = CMP_W'(pos_reg) < CMP_W'(count_reg);
    assign stat.full       = (count_reg == CNT_W'(CAPACITY));
    assign stat.shift_done = !has_next && !pend_reg;

    // one write port: append, overwrite, or the pending shift write
    always_comb begin
        mem_we = 1'b0;
        mem_wa = wa_reg;
        mem_wd = rd_data_reg;
        mem_re = 1'b0;
        mem_ra = ADDR_W'(pos_reg);
        if (cmd.append) begin
            mem_we = 1'b1;
            mem_wa = ADDR_W'(count_reg);
            mem_wd = val_reg;
        end else if (cmd.wr_pos) begin
            mem_we = 1'b1;
            mem_wa = ADDR_W'(pos_reg);
            mem_wd = val_reg;
        end else if (pend_reg) begin
            mem_we = 1'b1;
        end
        if (cmd.rd_pos) begin
            mem_re = 1'b1;
        end else if (cmd.shift_step && has_next) begin
            mem_re = 1'b1;
            mem_ra = ADDR_W'(idx_reg + CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.append) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.dec_count) begin
            count_next = count_reg - CNT_W'(1);
        end
        idx_next  = idx_reg;
        wa_next   = wa_reg;
        pend_next = 1'b0;
        if (cmd.shift_start) begin
            idx_next = CNT_W'(pos_reg);
        end else if (cmd.shift_step && has_next) begin
            pend_next = 1'b1;
            wa_next   = ADDR_W'(idx_reg);
            idx_next  = idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        wa_reg  <= wa_next;
        if (cmd.capture) begin
            op_reg  <= in_data[ilc_pkg::S_OPCODE_LSB +: ilc_pkg::OPCODE_W];
            pos_reg <= in_data[ilc_pkg::S_POS_LSB +: ilc_pkg::POS_W];
            val_reg <= WORD_BITS'(in_data[ilc_pkg::S_VALUE_LSB +: ilc_pkg::VALUE_W]);
        end
        if (cmd.load_out) begin
            out_value_reg  <= cmd.res_read ? ilc_pkg::VALUE_W'(rd_data_reg) : '0;
            out_status_reg <= cmd.res_status;
            out_count_reg  <= ilc_pkg::COUNT_OUT_W'(count_reg);
        end
    end

    always_comb begin
        out_data = '0;
        out_data[ilc_pkg::M_VALUE_LSB +: ilc_pkg::VALUE_W]      = out_value_reg;
        out_data[ilc_pkg::M_STATUS_LSB +: ilc_pkg::STATUS_W]    = out_status_reg;
        out_data[ilc_pkg::M_COUNT_LSB +: ilc_pkg::COUNT_OUT_W]  = out_count_reg;
    end

endmodule

`default_nettype wire

@@ design/ilc_controller.sv @@
// Controller of the indexed word list: sequences one request at a time
// and owns the output valid flag. Uses ilc_pkg command and status structs.
`default_nettype none

module ilc_controller (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    input  wire ilc_pkg::stat_t stat,
    output ilc_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_SHIFT,
        S_PUBLISH
    } state_t;

    state_t                       state_reg, state_next;
    logic [ilc_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                         rdsel_reg, rdsel_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        cmd         = '0;
        state_next  = state_reg;
        status_next = status_reg;
        rdsel_next  = rdsel_reg;
        cmd.res_status = status_reg;
        cmd.res_read   = rdsel_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                status_next = ilc_pkg::ST_OK;
                rdsel_next  = 1'b0;
                state_next  = S_PUBLISH;
                if (stat.op == ilc_pkg::OP_APPEND) begin
                    if (stat.full) begin
                        status_next = ilc_pkg::ST_FULL;
                    end else begin
                        cmd.append = 1'b1;
                    end
                end else if (!stat.in_range) begin
                    status_next = ilc_pkg::ST_RANGE;
                end else begin
                    unique case (stat.op)
                        ilc_pkg::OP_READ: begin
                            cmd.rd_pos = 1'b1;
                            rdsel_next = 1'b1;
                            state_next = S_RD_WAIT;
                        end
                        ilc_pkg::OP_WRITE: begin
                            cmd.wr_pos = 1'b1;
                        end
                        default: begin
                            cmd.shift_start = 1'b1;
                            state_next      = S_SHIFT;
                        end
                    endcase
                end
            end
            S_RD_WAIT: begin
                state_next = S_PUBLISH;
            end
            S_SHIFT: begin
                // move entries down until the last pending write lands
                if (stat.shift_done) begin
                    cmd.dec_count = 1'b1;
                    state_next    = S_PUBLISH;
                end else begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_PUBLISH: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            status_reg    <= ilc_pkg::ST_OK;
            rdsel_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            rdsel_reg     <= rdsel_next;
        end
    end

endmodule

`default_nettype wire

@@ design/ilc_checker.sv @@
// Port-level checks for the indexed word list, bound to the top level.
// Uses ilc_pkg field offsets and status codes.
`default_nettype none

module ilc_checker #(
    parameter int CAPACITY = ilc_pkg::DEF_CAPACITY
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [ilc_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [ilc_pkg::VALUE_W-1:0]     r_value;
    logic [ilc_pkg::STATUS_W-1:0]    r_status;
    logic [ilc_pkg::COUNT_OUT_W-1:0] r_count;

    assign r_value  = m_tdata[ilc_pkg::M_VALUE_LSB +: ilc_pkg::VALUE_W];
    assign r_status = m_tdata[ilc_pkg::M_STATUS_LSB +: ilc_pkg::STATUS_W];
    assign r_count  = m_tdata[ilc_pkg::M_COUNT_LSB +: ilc_pkg::COUNT_OUT_W];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (r_status == ilc_pkg::ST_OK || r_status == ilc_pkg::ST_RANGE
                      || r_status == ilc_pkg::ST_FULL))
        else $error("undefined status code");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r_status == ilc_pkg::ST_FULL
            |-> r_count == ilc_pkg::COUNT_OUT_W'(CAPACITY))
        else $error("full status with list not at capacity");

    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r_status != ilc_pkg::ST_OK |-> r_value == '0)
        else $error("failed request returned a nonzero word");

endmodule

bind indexed_list_with_compaction ilc_checker #(
    .CAPACITY (CAPACITY)
) u_ilc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
